// ===== src/pq_pkg.sv =====
// Package for the priority queue with purge.
// Holds the operation codes, slot and result types, and field widths; no dependencies.
package pq_pkg;

  localparam int ID_W     = 8;
  localparam int PRI_W    = 8;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 5;
  localparam int IN_DW    = 16;
  localparam int OUT_DW   = 24;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ   = 2'd0,
    KIND_DEQ   = 2'd1,
    KIND_PURGE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } slot_t;

  typedef struct packed {
    logic               hit;
    logic [ID_W-1:0]    id;
    logic [PRI_W-1:0]   pri;
    logic               is_empty;
    logic [COUNT_W-1:0] count;
  } pq_res_t;

endpackage

// ===== src/pq_mem.sv =====
// Slot store: one write port, one read port, registered read data.
// Depends on pq_pkg for slot_t.
module pq_mem #(
  parameter int QUEUE_DEPTH = 16,
  parameter int AW          = 4
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  pq_pkg::slot_t  wdata,
  input  logic [AW-1:0]  raddr,
  output pq_pkg::slot_t  rdata
);
  import pq_pkg::*;

  slot_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/pq_ctrl.sv =====
// Sequencer: enqueue, scan for the removal slot, then close up the queue.
// Depends on pq_pkg; drives the pq_mem ports.
module pq_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int AW          = 4,
  parameter int CW          = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pq_pkg::kind_t           in_kind,
  input  logic [pq_pkg::ID_W-1:0] in_id,
  input  logic [pq_pkg::PRI_W-1:0] in_pri,
  output logic                    res_valid,
  input  logic                    res_ready,
  output pq_pkg::pq_res_t         res,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output pq_pkg::slot_t           mem_wdata,
  output logic [AW-1:0]           mem_raddr,
  input  pq_pkg::slot_t           mem_rdata
);
  import pq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic              mode_r;
  logic [CW-1:0]     fill_r, fill_nxt;
  kind_t             op_r, op_nxt;
  logic [ID_W-1:0]   key_r, key_nxt;
  logic [CW-1:0]     lim_r, lim_nxt;
  logic [CW-1:0]     ra_r, ra_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]     chk_idx_r, chk_idx_nxt;
  logic              found_r, found_nxt;
  logic [AW-1:0]     sel_r, sel_nxt;
  logic              hit_r, hit_nxt;
  logic [ID_W-1:0]   rid_r, rid_nxt;
  logic [PRI_W-1:0]  rpri_r, rpri_nxt;
  logic [CW-1:0]     sh_rd_r, sh_rd_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt;

  logic              take;
  logic              scan_last;
  logic              found_f;
  logic [AW-1:0]     sel_f;
  logic              rd_issue;
  logic [CW-1:0]     lim_m1;
  logic [CW+COUNT_W-1:0] cnt_ext;

  assign lim_m1  = lim_r - CW'(1);
  assign cnt_ext = {{COUNT_W{1'b0}}, fill_r};

  always_comb begin
    res.hit      = hit_r;
    res.id       = rid_r;
    res.pri      = rpri_r;
    res.is_empty = (fill_r == '0);
    res.count    = cnt_ext[COUNT_W-1:0];
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign rd_issue  = (sh_rd_r < fill_r);

  always_comb begin
    take = 1'b0;
    if (chk_vld_r) begin
      case (op_r)
        KIND_DEQ:   take = (chk_idx_r == '0) || (mode_r && (mem_rdata.pri < rpri_r));
        KIND_PURGE: take = !found_r && (mem_rdata.id == key_r);
        default:    take = 1'b0;
      endcase
    end
  end

  assign scan_last = chk_vld_r && (CW'(chk_idx_r) == lim_m1);
  assign found_f   = found_r || take;
  assign sel_f     = take ? chk_idx_r : sel_r;

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    lim_nxt     = lim_r;
    ra_nxt      = ra_r;
    chk_vld_nxt = 1'b0;
    chk_idx_nxt = chk_idx_r;
    found_nxt   = found_r;
    sel_nxt     = sel_r;
    hit_nxt     = hit_r;
    rid_nxt     = rid_r;
    rpri_nxt    = rpri_r;
    sh_rd_nxt   = sh_rd_r;
    wr_pend_nxt = 1'b0;
    wr_addr_nxt = wr_addr_r;
    mem_we      = 1'b0;
    mem_waddr   = wr_addr_r;
    mem_wdata   = mem_rdata;
    mem_raddr   = (state_r == S_SHIFT) ? sh_rd_r[AW-1:0] : ra_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_kind;
          key_nxt   = in_id;
          hit_nxt   = 1'b0;
          rid_nxt   = '0;
          rpri_nxt  = '0;
          found_nxt = 1'b0;
          sel_nxt   = '0;
          ra_nxt    = '0;
          state_nxt = S_RESP;
          case (in_kind)
            KIND_ENQ: begin
              if (fill_r < CW'(QUEUE_DEPTH)) begin
                mem_we        = 1'b1;
                mem_waddr     = fill_r[AW-1:0];
                mem_wdata.id  = in_id;
                mem_wdata.pri = in_pri;
                fill_nxt      = fill_r + CW'(1);
                hit_nxt       = 1'b1;
              end
            end
            KIND_DEQ, KIND_PURGE: begin
              if (fill_r != '0) begin
                lim_nxt   = (in_kind == KIND_DEQ && !mode_r) ? CW'(1) : fill_r;
                state_nxt = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (ra_r < lim_r) begin
          ra_nxt      = ra_r + CW'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = ra_r[AW-1:0];
        end
        if (take) begin
          found_nxt = 1'b1;
          sel_nxt   = chk_idx_r;
          rid_nxt   = mem_rdata.id;
          rpri_nxt  = mem_rdata.pri;
        end
        if (scan_last) begin
          chk_vld_nxt = 1'b0;
          if (found_f) begin
            hit_nxt   = 1'b1;
            sh_rd_nxt = CW'(sel_f) + CW'(1);
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SHIFT: begin
        // read slot k+1 while slot k's data is written back into slot k-1
        if (wr_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_r;
          mem_wdata = mem_rdata;
        end
        if (rd_issue) begin
          sh_rd_nxt   = sh_rd_r + CW'(1);
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = sh_rd_r[AW-1:0] - AW'(1);
        end else if (!wr_pend_r) begin
          fill_nxt  = fill_r - CW'(1);
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mode_r    <= 1'b1;
      fill_r    <= '0;
      chk_vld_r <= 1'b0;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      chk_vld_r <= chk_vld_nxt;
      wr_pend_r <= wr_pend_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    lim_r     <= lim_nxt;
    ra_r      <= ra_nxt;
    chk_idx_r <= chk_idx_nxt;
    found_r   <= found_nxt;
    sel_r     <= sel_nxt;
    hit_r     <= hit_nxt;
    rid_r     <= rid_nxt;
    rpri_r    <= rpri_nxt;
    sh_rd_r   <= sh_rd_nxt;
    wr_addr_r <= wr_addr_nxt;
  end

endmodule

// ===== src/priority_queue_with_purge_top.sv =====
// Top level of the priority queue with purge: sequencer, slot store, output register.
// Depends on pq_pkg, pq_mem and pq_ctrl.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | tuser: kind; tdata: entry_id, priority_req
//   out_    | out | out_tvalid/tready  | tdata: hit, out_id, out_priority, is_empty, count
//   cfg_    | in  | cfg_wr_en          | cfg_wr_data: priority_mode
//
// Enqueue, a miss on an empty queue and an unknown kind go straight to the result, with no scan.
// Priority dequeue and purge read each held slot once to find the slot, then close up
// behind it at one read and one write a cycle, paced by the single read port of the
// slot store; FIFO dequeue reads only the head to find the slot.
// Sync active-low reset clears the fill count and sets priority mode; slot contents are
// not cleared. The output register lets the next beat in while a result waits on out_tready.
module priority_queue_with_purge_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data,   // priority_mode
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [pq_pkg::IN_DW-1:0] in_tdata,      // entry_id[7:0], priority_req[15:8]
  input  logic [pq_pkg::KIND_W-1:0] in_tuser,     // kind[1:0]
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [pq_pkg::OUT_DW-1:0] out_tdata     // hit[0], out_id[8:1], out_priority[16:9],
                                                  // is_empty[17], count[22:18], zero[23]
);
  import pq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  slot_t              mem_wdata;
  slot_t              mem_rdata;
  logic               res_valid;
  logic               res_ready;
  pq_res_t            res;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0]  out_data_r;

  pq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_kind     (kind_t'(in_tuser)),
    .in_id       (in_tdata[ID_W-1:0]),
    .in_pri      (in_tdata[ID_W+PRI_W-1:ID_W]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  pq_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= {1'b0, res.count, res.is_empty, res.pri, res.id, res.hit};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.hit) |-> (res.id == '0 && res.pri == '0))
    else $error("miss result carries a removed entry");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready while a beat is in progress");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> !res_valid)
    else $error("result offered twice");

  a_no_beat_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_tready)
    else $error("beat accepted before result handed over");

endmodule
